FILE: src/sbl_pkg.sv
// Shared types, constants and helpers for the Sobel RGB edge core.
package sbl_pkg;

    localparam int PIX_W = 24;
    localparam int CH_W  = 8;

    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int THR_W    = 10;
    localparam int CFG_W    = 16;
    localparam int ITEM_W   = 27;

    localparam int GRAD_W   = 12;
    localparam int ABS_W    = 10;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_EDGE_THRESHOLD = 2'd2;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 16'd480;
    localparam logic [THR_W-1:0]    RST_THR    = 10'd100;
    localparam logic [ITEM_W-1:0]   RST_TOTAL  = 27'd307200;

    localparam logic [7:0] MAG_MAX = 8'd255;
    localparam logic [20:0] MAG_SAT_LIMIT = 21'd65280;

    localparam int KERN_X [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    localparam int KERN_Y [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_GRAD,
        S_MST,
        S_MAG,
        S_OUT,
        S_TOTAL,
        S_DIV
    } t_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_SQ,
        M_ITER
    } t_mag_phase;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_mask;

    // Sobel coefficient times an unsigned channel value
    function automatic logic signed [GRAD_W-1:0] kmul(input logic [CH_W-1:0] v, input int kc);
        logic signed [GRAD_W-1:0] sv;
        sv = $signed({4'b0000, v});
        case (kc)
            -2:      kmul = -(sv <<< 1);
            -1:      kmul = -sv;
            1:       kmul = sv;
            2:       kmul = sv <<< 1;
            default: kmul = '0;
        endcase
    endfunction

endpackage

FILE: src/sbl_linebuf.sv
// Line store memory: upper and middle rows packed per column, registered read.
module sbl_linebuf
    import sbl_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [2*PIX_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [2*PIX_W-1:0] i_wr_data
);

    logic [2*PIX_W-1:0] r_mem [DEPTH];
    logic [2*PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/sbl_mag.sv
// Magnitude lane: round(sqrt(gx^2 + gy^2)) clamped to 255, one root bit per cycle.
module sbl_mag
    import sbl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ABS_W-1:0] i_gx_abs,
    input  logic [ABS_W-1:0] i_gy_abs,
    output logic             o_done,
    output logic [CH_W-1:0]  o_mag
);

    t_mag_phase r_phase;
    logic [2*ABS_W-1:0] r_sqx;
    logic [2*ABS_W-1:0] r_sqy;
    logic [16:0]        r_rem;
    logic [15:0]        r_root;
    logic [15:0]        r_bit;
    logic [2:0]         r_cnt;
    logic               r_big;
    logic               r_done;
    logic [CH_W-1:0]    r_mag;

    logic [2*ABS_W:0]   sum;
    logic [16:0]        trial;
    logic [16:0]        n_rem;
    logic [15:0]        n_root;

    assign sum   = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign trial = {1'b0, r_root} + {1'b0, r_bit};

    always_comb begin
        if (r_rem >= trial) begin
            n_rem  = r_rem - trial;
            n_root = (r_root >> 1) + r_bit;
        end else begin
            n_rem  = r_rem;
            n_root = r_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                M_IDLE: begin
                    if (i_start) begin
                        r_phase <= M_SQ;
                    end
                end
                M_SQ: begin
                    r_phase <= M_ITER;
                end
                M_ITER: begin
                    if (r_cnt == 3'd7) begin
                        r_phase <= M_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_phase <= M_IDLE;
            endcase
            if (i_start) begin
                r_phase <= M_SQ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sqx <= i_gx_abs * i_gx_abs;
            r_sqy <= i_gy_abs * i_gy_abs;
        end else if (r_phase == M_SQ) begin
            r_big  <= (sum > MAG_SAT_LIMIT);
            r_rem  <= {1'b0, sum[15:0]};
            r_root <= '0;
            r_bit  <= 16'h4000;
            r_cnt  <= '0;
        end else if (r_phase == M_ITER) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_bit  <= r_bit >> 2;
            r_cnt  <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                // round up when the remainder exceeds the floor root
                if (r_big) begin
                    r_mag <= MAG_MAX;
                end else if (n_rem > {1'b0, n_root}) begin
                    r_mag <= n_root[7:0] + 8'd1;
                end else begin
                    r_mag <= n_root[7:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_mag;

endmodule

FILE: src/sbl_div.sv
// Restoring divider: recovers the output row and column after a register change.
module sbl_div
    import sbl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ITEM_W-1:0]  i_dividend,
    input  logic [WIDTH_W-1:0] i_divisor,
    output logic               o_done,
    output logic [ITEM_W-1:0]  o_quot,
    output logic [WIDTH_W-1:0] o_rem
);

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic [WIDTH_W-1:0] r_div;
    logic [WIDTH_W:0]   r_rem;
    logic [ITEM_W-1:0]  r_quo;

    logic [WIDTH_W:0]   trial;
    logic               take;

    assign trial = {r_rem[WIDTH_W-1:0], r_quo[ITEM_W-1]};
    assign take  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'(ITEM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            r_rem <= take ? (trial - {1'b0, r_div}) : trial;
            r_quo <= {r_quo[ITEM_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem[WIDTH_W-1:0];

endmodule

FILE: src/sobel_edge_rgb_3x3_core.sv
// Top level of the 3x3 Sobel RGB edge core with line stores and window.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+---------------------------------------------
//  input   | i_in_valid | o_in_stall  | i_operation, i_red_in, i_green_in, i_blue_in
//  output  | o_out_valid| i_out_stall | o_red_out, o_green_out, o_blue_out, o_frame_last
//  config  | i_cfg_we   | -           | i_cfg_index, i_cfg_data
//
// An item that yields a result passes S_READ, S_GRAD, S_MST, S_MAG and S_OUT on its way
// to the output register, and the next transaction is accepted once the core is back in
// S_IDLE; an item without a result passes only S_READ. The span is set by the magnitude
// lanes, which resolve one root bit per cycle. A register write once results are due
// costs a recalculation (product W*H, then a bit-serial divide), otherwise only the
// product, during which no transaction is accepted.
// Reset is synchronous; the output register holds its result while the sink stalls.
module sobel_edge_rgb_3x3_core
    import sbl_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_operation,
    input  logic [CH_W-1:0]   i_red_in,
    input  logic [CH_W-1:0]   i_green_in,
    input  logic [CH_W-1:0]   i_blue_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CH_W-1:0]   o_red_out,
    output logic [CH_W-1:0]   o_green_out,
    output logic [CH_W-1:0]   o_blue_out,
    output logic              o_frame_last,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int MAXW_C = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;

    t_state r_state;
    t_state n_state;

    logic [WIDTH_W-1:0]  r_fw;
    logic [HEIGHT_W-1:0] r_fh;
    logic [THR_W-1:0]    r_thr;
    logic [ITEM_W-1:0]   r_total;
    logic [ITEM_W-1:0]   r_items;
    logic [AW-1:0]       r_col;
    logic [WIDTH_W-1:0]  r_ocol;
    logic [HEIGHT_W-1:0] r_orow;

    t_pix  r_pixel;
    t_pix  r_win [9];
    t_mask r_mask;
    logic  r_last;
    logic  r_small;
    t_pix  r_centre;
    logic [ABS_W-1:0] r_gxa [3];
    logic [ABS_W-1:0] r_gya [3];

    logic             r_out_valid;
    logic [CH_W-1:0]  r_red;
    logic [CH_W-1:0]  r_green;
    logic [CH_W-1:0]  r_blue;
    logic             r_frame_last;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                accept;
    logic                in_frame;
    logic                rd_en;
    logic [2*PIX_W-1:0]  rd_data;
    t_pix                up_pix;
    t_pix                mid_pix;
    logic                has_result;
    logic                is_last;
    logic [ITEM_W-1:0]   q_pos;
    logic                col_wrap;
    logic                ocol_wrap;
    logic                div_start;
    logic                div_done;
    logic [ITEM_W-1:0]   div_quot;
    logic [WIDTH_W-1:0]  div_rem;
    logic [2:0]          mag_done;
    logic [CH_W-1:0]     mag_val [3];
    logic                out_free;

    t_pix                nb [9];
    logic signed [GRAD_W-1:0] gx [3];
    logic signed [GRAD_W-1:0] gy [3];
    logic [GRAD_W-1:0]   gxa [3];
    logic [GRAD_W-1:0]   gya [3];
    logic                small_now;

    // Effective frame size
    always_comb begin
        if (r_fw == '0) begin
            w_eff = 11'd1;
        end else if (r_fw > 11'(MAXW_C)) begin
            w_eff = 11'(MAXW_C);
        end else begin
            w_eff = r_fw;
        end
        h_eff = (r_fh == '0) ? 16'd1 : r_fh;
    end

    assign o_in_stall = (r_state != S_IDLE) || i_cfg_we;
    assign accept     = i_in_valid && !o_in_stall;
    assign in_frame   = (r_items < r_total);
    assign rd_en      = accept && !(in_frame && i_operation);
    assign up_pix     = rd_data[2*PIX_W-1:PIX_W];
    assign mid_pix    = rd_data[PIX_W-1:0];

    assign has_result = ({1'b0, r_items} >= ({17'b0, w_eff} + 28'd1));
    assign is_last    = ({1'b0, r_items} >= ({1'b0, r_total} + {17'b0, w_eff}));
    assign q_pos      = r_items - {16'b0, w_eff} - 27'd1;
    assign col_wrap   = ((16'(r_col) + 16'd1) >= 16'(w_eff));
    assign ocol_wrap  = (({1'b0, r_ocol} + 12'd1) >= {1'b0, w_eff});
    assign out_free   = !r_out_valid || !i_out_stall;
    assign div_start  = (r_state == S_TOTAL) && has_result;

    sbl_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == S_READ),
        .i_wr_addr (r_col),
        .i_wr_data ({mid_pix, r_pixel})
    );

    sbl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (q_pos),
        .i_divisor  (w_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        sbl_mag u_mag (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (r_state == S_MST),
            .i_gx_abs (r_gxa[g]),
            .i_gy_abs (r_gya[g]),
            .o_done   (mag_done[g]),
            .o_mag    (mag_val[g])
        );
    end

    // Masked neighborhood and gradients
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            nb[k] = r_win[k];
        end
        if (r_mask.top) begin
            nb[0] = '0; nb[1] = '0; nb[2] = '0;
        end
        if (r_mask.bottom) begin
            nb[6] = '0; nb[7] = '0; nb[8] = '0;
        end
        if (r_mask.left) begin
            nb[0] = '0; nb[3] = '0; nb[6] = '0;
        end
        if (r_mask.right) begin
            nb[2] = '0; nb[5] = '0; nb[8] = '0;
        end
        small_now = 1'b1;
        for (int ch = 0; ch < 3; ch++) begin
            gx[ch] = '0;
            gy[ch] = '0;
            for (int k = 0; k < 9; k++) begin
                gx[ch] = gx[ch] + kmul(nb[k][PIX_W-1-CH_W*ch -: CH_W], KERN_X[k]);
                gy[ch] = gy[ch] + kmul(nb[k][PIX_W-1-CH_W*ch -: CH_W], KERN_Y[k]);
            end
            gxa[ch] = (gx[ch] < 0) ? 12'(-gx[ch]) : 12'(gx[ch]);
            gya[ch] = (gy[ch] < 0) ? 12'(-gy[ch]) : 12'(gy[ch]);
            if (gxa[ch] >= {2'b00, r_thr} || gya[ch] >= {2'b00, r_thr}) begin
                small_now = 1'b0;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_state = S_TOTAL;
                end else if (rd_en) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = has_result ? S_GRAD : S_IDLE;
            S_GRAD:  n_state = S_MST;
            S_MST:   n_state = S_MAG;
            S_MAG:   n_state = (&mag_done) ? S_OUT : S_MAG;
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            S_TOTAL: begin
                if (i_cfg_we) begin
                    n_state = S_TOTAL;
                end else begin
                    n_state = has_result ? S_DIV : S_IDLE;
                end
            end
            S_DIV: begin
                if (i_cfg_we) begin
                    n_state = S_TOTAL;
                end else if (div_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= RST_WIDTH;
            r_fh  <= RST_HEIGHT;
            r_thr <= RST_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:    r_fw  <= i_cfg_data[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT:   r_fh  <= i_cfg_data[HEIGHT_W-1:0];
                CFG_EDGE_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame counters and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= RST_TOTAL;
            r_items <= '0;
            r_col   <= '0;
            r_ocol  <= '0;
            r_orow  <= '0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            case (r_state)
                S_READ: begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[k*3]     <= r_win[k*3+1];
                        r_win[k*3 + 1] <= r_win[k*3+2];
                    end
                    r_win[2] <= up_pix;
                    r_win[5] <= mid_pix;
                    r_win[8] <= r_pixel;
                    r_col    <= col_wrap ? '0 : r_col + AW'(1);
                    r_items  <= r_items + 27'd1;
                    if (has_result) begin
                        if (ocol_wrap) begin
                            r_ocol <= '0;
                            r_orow <= (&r_orow) ? r_orow : r_orow + 16'd1;
                        end else begin
                            r_ocol <= r_ocol + 11'd1;
                        end
                        if (is_last) begin
                            r_items <= '0;
                            r_col   <= '0;
                            r_ocol  <= '0;
                            r_orow  <= '0;
                        end
                    end
                end
                S_TOTAL: begin
                    r_total <= w_eff * h_eff;
                    if (!has_result) begin
                        r_ocol <= '0;
                        r_orow <= '0;
                    end
                end
                S_DIV: begin
                    if (div_done && !i_cfg_we) begin
                        r_ocol <= div_rem;
                        r_orow <= (|div_quot[ITEM_W-1:HEIGHT_W]) ? '1 : div_quot[HEIGHT_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers for one item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel <= in_frame ? {i_red_in, i_green_in, i_blue_in} : '0;
        end
        if (r_state == S_READ) begin
            r_mask.top    <= (r_orow == '0);
            r_mask.bottom <= (({1'b0, r_orow} + 17'd1) >= {1'b0, h_eff});
            r_mask.left   <= (r_ocol == '0);
            r_mask.right  <= ocol_wrap;
            r_last        <= is_last;
        end
        if (r_state == S_GRAD) begin
            r_small  <= small_now;
            r_centre <= r_win[4];
            for (int ch = 0; ch < 3; ch++) begin
                r_gxa[ch] <= gxa[ch][ABS_W-1:0];
                r_gya[ch] <= gya[ch][ABS_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_red        <= r_small ? r_centre[23:16] : mag_val[0];
            r_green      <= r_small ? r_centre[15:8]  : mag_val[1];
            r_blue       <= r_small ? r_centre[7:0]   : mag_val[2];
            r_frame_last <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red_out    = r_red;
    assign o_green_out  = r_green;
    assign o_blue_out   = r_blue;
    assign o_frame_last = r_frame_last;

endmodule
